// ----- src/tes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and constants for the linear triangle element stiffness
// pipeline: word formats, default widths, multiplier latency and index tables.
// ----------------------------------------------------------------------------
package tes_pkg;

   // default widths
   localparam int COORD_WIDTH_DEF = 32;
   localparam int OUT_WIDTH_DEF   = 32;

   // pipelined multiplier latency
   localparam int MUL_LAT = 4;

   // fixed point alignment shifts
   localparam int K_SHIFT    = 15;
   localparam int FLUX_SHIFT = 14;
   localparam int SQ_SHIFT   = 22;

   // distinct entries of the symmetric element matrix
   localparam int NUM_K = 6;
   localparam int K_ROW [NUM_K] = '{0, 0, 0, 1, 1, 2};
   localparam int K_COL [NUM_K] = '{0, 1, 2, 1, 2, 2};

   // input word
   typedef struct packed {
      logic signed [31:0] vert0_x;
      logic signed [31:0] vert0_y;
      logic signed [31:0] vert1_x;
      logic signed [31:0] vert1_y;
      logic signed [31:0] vert2_x;
      logic signed [31:0] vert2_y;
      logic signed [31:0] pot0;
      logic signed [31:0] pot1;
      logic signed [31:0] pot2;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [63:0] area;
      logic signed [31:0] k00;
      logic signed [31:0] k01;
      logic signed [31:0] k02;
      logic signed [31:0] k11;
      logic signed [31:0] k12;
      logic signed [31:0] k22;
      logic signed [31:0] flux_x;
      logic signed [31:0] flux_y;
      logic        [31:0] flux_sq;
      logic               neg_area;
      logic               zero_area;
   } rsp_type;

   // area and flags carried alongside the dividers
   typedef struct packed {
      logic signed [63:0] area;
      logic               neg;
      logic               zero;
   } side_type;

endpackage

// ----- src/triangle_element_stiffness.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_element_stiffness
// Element matrix, area and flux density of one linear triangle per word.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle is accepted every clock unless a finished
// result is held back. Depth is set by the dividers, which retire one
// quotient bit per stage; the multipliers add four stages each for the
// products and for B squared. When a result is not taken the whole
// pipeline holds, nothing is lost.
// ----------------------------------------------------------------------------
module triangle_element_stiffness #(
   parameter int COORD_WIDTH = tes_pkg::COORD_WIDTH_DEF,
   parameter int OUT_WIDTH   = tes_pkg::OUT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tes_pkg::rsp_type rsp_data
);
   import tes_pkg::*;

   localparam int CW       = COORD_WIDTH;
   localparam int OW       = OUT_WIDTH;
   localparam int DFW      = CW + 1;
   localparam int TW       = 2 * CW + 3;
   localparam int FMW      = (DFW > 32) ? DFW : 32;
   localparam int FW       = CW + 35;
   localparam int NWK      = TW + K_SHIFT;
   localparam int NWF      = FW + FLUX_SHIFT;
   localparam int DIV_LAT  = OW + 2;
   localparam int SIDE_DLY = DIV_LAT + MUL_LAT;
   localparam int NSTG     = OW + 15;
   localparam int AW       = TW - 1;
   localparam int EXW      = (AW > 64) ? AW : 64;
   localparam int SQW      = 2 * OW + 1;

   logic                  en;
   logic [NSTG-1:0]       vld_ff;
   req_type               in_ff;

   logic signed [CW-1:0]  xv [3];
   logic signed [CW-1:0]  yv [3];
   logic signed [DFW-1:0] c_in [3];
   logic signed [DFW-1:0] d_in [3];
   logic signed [DFW-1:0] c_ff [3];
   logic signed [DFW-1:0] d_ff [3];
   logic signed [31:0]    pot_in [3];
   logic signed [31:0]    pot_ff [3];

   logic signed [2*DFW-1:0] two_pa, two_pb;
   logic signed [2*DFW-1:0] kcc [NUM_K];
   logic signed [2*DFW-1:0] kdd [NUM_K];
   logic signed [2*FMW-1:0] fdx [3];
   logic signed [2*FMW-1:0] fcy [3];

   logic signed [TW-1:0]  two_ff;
   logic signed [TW-1:0]  knum_ff [NUM_K];
   logic signed [FW-1:0]  sx_ff, sy_ff;

   logic                  two_neg;
   logic [TW-1:0]         den_in, den_ff;
   logic [TW-1:0]         kmag [NUM_K];
   logic [NWK-1:0]        knm_in [NUM_K];
   logic [NWK-1:0]        knm_ff [NUM_K];
   logic                  kneg_in [NUM_K];
   logic                  kneg_ff [NUM_K];
   logic [FW-1:0]         sxmag, symag;
   logic [NWF-1:0]        fxn_in, fyn_in, fxn_ff, fyn_ff;
   logic                  fxneg_in, fyneg_in, fxneg_ff, fyneg_ff;
   logic signed [AW-1:0]  half;
   logic signed [EXW-1:0] halfx;
   side_type              side_in, side_ff;

   logic signed [OW-1:0]  kq [NUM_K];
   logic signed [OW-1:0]  bx_q, by_q;
   logic signed [2*OW-1:0] sqx, sqy;
   logic signed [OW-1:0]  qv [NUM_K+2];
   logic signed [OW-1:0]  qd_ff [MUL_LAT][NUM_K+2];
   side_type              side_dly_ff [SIDE_DLY];

   logic [SQW-1:0]        sqsum, sqsh;
   logic [OW-1:0]         fsq;
   side_type              sd;
   rsp_type               rsp_in, rsp_ff;

   // pipeline advance: everything moves unless a finished word is stuck
   assign rsp_valid = vld_ff[NSTG-1];
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // edge vectors c and d
   always_comb begin
      xv[0] = CW'(in_ff.vert0_x);
      yv[0] = CW'(in_ff.vert0_y);
      xv[1] = CW'(in_ff.vert1_x);
      yv[1] = CW'(in_ff.vert1_y);
      xv[2] = CW'(in_ff.vert2_x);
      yv[2] = CW'(in_ff.vert2_y);
      pot_in[0] = in_ff.pot0;
      pot_in[1] = in_ff.pot1;
      pot_in[2] = in_ff.pot2;
      for (int i = 0; i < 3; i++) begin
         c_in[i] = DFW'(yv[(i + 1) % 3]) - DFW'(yv[(i + 2) % 3]);
         d_in[i] = DFW'(xv[(i + 2) % 3]) - DFW'(xv[(i + 1) % 3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_data;
         for (int i = 0; i < 3; i++) begin
            c_ff[i]   <= c_in[i];
            d_ff[i]   <= d_in[i];
            pot_ff[i] <= pot_in[i];
         end
      end
   end

   // twice the area from two cross terms
   tes_mul #(.W(DFW)) u_two_a (
      .clock(clock), .en(en), .a(d_ff[2]), .b(c_ff[1]), .p(two_pa)
   );
   tes_mul #(.W(DFW)) u_two_b (
      .clock(clock), .en(en), .a(d_ff[1]), .b(c_ff[2]), .p(two_pb)
   );

   // matrix numerators and flux sums
   for (genvar g = 0; g < NUM_K; g++) begin : g_kmul
      tes_mul #(.W(DFW)) u_cc (
         .clock(clock), .en(en),
         .a(c_ff[K_ROW[g]]), .b(c_ff[K_COL[g]]), .p(kcc[g])
      );
      tes_mul #(.W(DFW)) u_dd (
         .clock(clock), .en(en),
         .a(d_ff[K_ROW[g]]), .b(d_ff[K_COL[g]]), .p(kdd[g])
      );
   end

   for (genvar g = 0; g < 3; g++) begin : g_fmul
      tes_mul #(.W(FMW)) u_dx (
         .clock(clock), .en(en),
         .a(FMW'(d_ff[g])), .b(FMW'(pot_ff[g])), .p(fdx[g])
      );
      tes_mul #(.W(FMW)) u_cy (
         .clock(clock), .en(en),
         .a(FMW'(c_ff[g])), .b(FMW'(pot_ff[g])), .p(fcy[g])
      );
   end

   // product sums
   always_ff @(posedge clock) begin
      if (en) begin
         two_ff <= TW'(two_pa) - TW'(two_pb);
         for (int i = 0; i < NUM_K; i++) begin
            knum_ff[i] <= TW'(kcc[i]) + TW'(kdd[i]);
         end
         sx_ff <= FW'(fdx[0]) + FW'(fdx[1]) + FW'(fdx[2]);
         sy_ff <= FW'(fcy[0]) + FW'(fcy[1]) + FW'(fcy[2]);
      end
   end

   // magnitudes, quotient signs, area and flags
   always_comb begin
      two_neg = two_ff[TW-1];
      den_in  = two_neg ? -two_ff : two_ff;
      for (int i = 0; i < NUM_K; i++) begin
         kmag[i]    = knum_ff[i][TW-1] ? -knum_ff[i] : knum_ff[i];
         knm_in[i]  = {kmag[i], {K_SHIFT{1'b0}}};
         kneg_in[i] = knum_ff[i][TW-1] ^ two_neg;
      end
      sxmag    = sx_ff[FW-1] ? -sx_ff : sx_ff;
      symag    = sy_ff[FW-1] ? -sy_ff : sy_ff;
      fxn_in   = {sxmag, {FLUX_SHIFT{1'b0}}};
      fyn_in   = {symag, {FLUX_SHIFT{1'b0}}};
      fxneg_in = sx_ff[FW-1] ^ two_neg;
      fyneg_in = !sy_ff[FW-1] ^ two_neg;

      // floored half of twice the area, clipped to 64 bits
      half  = AW'(two_ff >>> 1);
      halfx = EXW'(half);
      if ((&halfx[EXW-1:63]) || !(|halfx[EXW-1:63])) begin
         side_in.area = halfx[63:0];
      end else if (halfx[EXW-1]) begin
         side_in.area = {1'b1, {63{1'b0}}};
      end else begin
         side_in.area = {1'b0, {63{1'b1}}};
      end
      side_in.neg  = two_neg;
      side_in.zero = (two_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= den_in;
         for (int i = 0; i < NUM_K; i++) begin
            knm_ff[i]  <= knm_in[i];
            kneg_ff[i] <= kneg_in[i];
         end
         fxn_ff   <= fxn_in;
         fyn_ff   <= fyn_in;
         fxneg_ff <= fxneg_in;
         fyneg_ff <= fyneg_in;
         side_ff  <= side_in;
      end
   end

   // dividers
   for (genvar g = 0; g < NUM_K; g++) begin : g_kdiv
      tes_div #(.NW(NWK), .DW(TW), .QW(OW)) u_div (
         .clock(clock), .en(en),
         .num(knm_ff[g]), .den(den_ff), .neg(kneg_ff[g]), .q(kq[g])
      );
   end

   tes_div #(.NW(NWF), .DW(TW), .QW(OW)) u_div_bx (
      .clock(clock), .en(en), .num(fxn_ff), .den(den_ff), .neg(fxneg_ff), .q(bx_q)
   );
   tes_div #(.NW(NWF), .DW(TW), .QW(OW)) u_div_by (
      .clock(clock), .en(en), .num(fyn_ff), .den(den_ff), .neg(fyneg_ff), .q(by_q)
   );

   // flux squared
   tes_mul #(.W(OW)) u_sq_x (
      .clock(clock), .en(en), .a(bx_q), .b(bx_q), .p(sqx)
   );
   tes_mul #(.W(OW)) u_sq_y (
      .clock(clock), .en(en), .a(by_q), .b(by_q), .p(sqy)
   );

   // alignment delays for quotients and side data
   always_comb begin
      for (int i = 0; i < NUM_K; i++) begin
         qv[i] = kq[i];
      end
      qv[NUM_K]     = bx_q;
      qv[NUM_K + 1] = by_q;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qd_ff[0] <= qv;
         for (int s = 1; s < MUL_LAT; s++) begin
            qd_ff[s] <= qd_ff[s-1];
         end
         side_dly_ff[0] <= side_ff;
         for (int s = 1; s < SIDE_DLY; s++) begin
            side_dly_ff[s] <= side_dly_ff[s-1];
         end
      end
   end

   // output word assembly
   always_comb begin
      sqsum = SQW'($unsigned(sqx)) + SQW'($unsigned(sqy));
      sqsh  = sqsum >> SQ_SHIFT;
      fsq   = (|sqsh[SQW-1:OW]) ? {OW{1'b1}} : sqsh[OW-1:0];
      sd    = side_dly_ff[SIDE_DLY-1];
      rsp_in = '0;
      if (sd.zero) begin
         rsp_in.zero_area = 1'b1;
      end else begin
         rsp_in.area     = sd.area;
         rsp_in.k00      = 32'(qd_ff[MUL_LAT-1][0]);
         rsp_in.k01      = 32'(qd_ff[MUL_LAT-1][1]);
         rsp_in.k02      = 32'(qd_ff[MUL_LAT-1][2]);
         rsp_in.k11      = 32'(qd_ff[MUL_LAT-1][3]);
         rsp_in.k12      = 32'(qd_ff[MUL_LAT-1][4]);
         rsp_in.k22      = 32'(qd_ff[MUL_LAT-1][5]);
         rsp_in.flux_x   = 32'(qd_ff[MUL_LAT-1][NUM_K]);
         rsp_in.flux_y   = 32'(qd_ff[MUL_LAT-1][NUM_K + 1]);
         rsp_in.flux_sq  = 32'(fsq);
         rsp_in.neg_area = sd.neg;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/tes_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_mul
// Pipelined signed multiplier: magnitudes, four half-width partial
// products, partial product sum, sign restore. Four register stages.
// ----------------------------------------------------------------------------
module tes_mul #(
   parameter int W = 33
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [W-1:0]   a,
   input  logic signed [W-1:0]   b,
   output logic signed [2*W-1:0] p
);
   localparam int LO = W / 2;
   localparam int HI = W - LO;

   logic [W-1:0]        ma_ff, mb_ff, ma_in, mb_in;
   logic                neg1_ff, neg2_ff, neg3_ff;
   logic [2*LO-1:0]     ll_ff;
   logic [LO+HI-1:0]    lh_ff, hl_ff;
   logic [2*HI-1:0]     hh_ff;
   logic [2*W-1:0]      sum_ff, sum_in;
   logic signed [2*W-1:0] p_ff;

   // operand magnitudes and partial product sum
   always_comb begin
      ma_in  = a[W-1] ? -a : a;
      mb_in  = b[W-1] ? -b : b;
      sum_in = {hh_ff, {(2*LO){1'b0}}}
             + (2*W)'({lh_ff, {LO{1'b0}}})
             + (2*W)'({hl_ff, {LO{1'b0}}})
             + (2*W)'(ll_ff);
   end

   // stages
   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg1_ff <= a[W-1] ^ b[W-1];
         ll_ff   <= ma_ff[LO-1:0] * mb_ff[LO-1:0];
         lh_ff   <= ma_ff[LO-1:0] * mb_ff[W-1:LO];
         hl_ff   <= ma_ff[W-1:LO] * mb_ff[LO-1:0];
         hh_ff   <= ma_ff[W-1:LO] * mb_ff[W-1:LO];
         neg2_ff <= neg1_ff;
         sum_ff  <= sum_in;
         neg3_ff <= neg2_ff;
         p_ff    <= neg3_ff ? -sum_ff : sum_ff;
      end
   end

   assign p = p_ff;

endmodule

// ----- src/tes_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage,
// with overflow check up front and signed saturation at the end.
// ----------------------------------------------------------------------------
module tes_div #(
   parameter int NW = 81,
   parameter int DW = 67,
   parameter int QW = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [NW-1:0]        num,
   input  logic [DW-1:0]        den,
   input  logic                 neg,
   output logic signed [QW-1:0] q
);
   localparam int HW  = NW - QW;
   localparam int CMW = (HW > DW) ? HW : DW;
   localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_MAG = {1'b1, {(QW-1){1'b0}}};

   logic [DW-1:0] rem_ff [QW+1];
   logic [DW-1:0] rem_in [QW+1];
   logic [QW-1:0] low_ff [QW+1];
   logic [QW-1:0] low_in [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic [QW-1:0] quo_in [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [DW-1:0] den_in [QW+1];
   logic          ovf_ff [QW+1];
   logic          ovf_in [QW+1];
   logic          neg_ff [QW+1];
   logic          neg_in [QW+1];
   logic [DW:0]   trial  [QW];
   logic [QW-1:0] q_in;
   logic signed [QW-1:0] q_ff;

   // entry: high part must stay below the divisor, else the quotient overflows
   always_comb begin
      rem_in[0] = DW'(num[NW-1:QW]);
      low_in[0] = num[QW-1:0];
      quo_in[0] = '0;
      den_in[0] = den;
      ovf_in[0] = CMW'(num[NW-1:QW]) >= CMW'(den);
      neg_in[0] = neg;
      // one quotient bit per stage
      for (int i = 0; i < QW; i++) begin
         trial[i] = {rem_ff[i], low_ff[i][QW-1]};
         if (trial[i] >= {1'b0, den_ff[i]}) begin
            rem_in[i+1] = DW'(trial[i] - {1'b0, den_ff[i]});
            quo_in[i+1] = {quo_ff[i][QW-2:0], 1'b1};
         end else begin
            rem_in[i+1] = DW'(trial[i]);
            quo_in[i+1] = {quo_ff[i][QW-2:0], 1'b0};
         end
         low_in[i+1] = {low_ff[i][QW-2:0], 1'b0};
         den_in[i+1] = den_ff[i];
         ovf_in[i+1] = ovf_ff[i];
         neg_in[i+1] = neg_ff[i];
      end
   end

   // signed saturation of the finished quotient
   always_comb begin
      if (neg_ff[QW]) begin
         if (ovf_ff[QW] || quo_ff[QW] > NEG_MAG) begin
            q_in = NEG_MAG;
         end else begin
            q_in = -quo_ff[QW];
         end
      end else begin
         if (ovf_ff[QW] || quo_ff[QW] > POS_MAX) begin
            q_in = POS_MAX;
         end else begin
            q_in = quo_ff[QW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= QW; i++) begin
            rem_ff[i] <= rem_in[i];
            low_ff[i] <= low_in[i];
            quo_ff[i] <= quo_in[i];
            den_ff[i] <= den_in[i];
            ovf_ff[i] <= ovf_in[i];
            neg_ff[i] <= neg_in[i];
         end
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule
